// ===== src/bsac_pkg.sv =====
`default_nettype none

package bsac_pkg;

    localparam int NUM_BLOCKS = 4;
    localparam int SETTLE_W   = 16;
    localparam int COUNT_W    = 17;
    localparam int ASPECT_W   = 2;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

    typedef logic [ASPECT_W-1:0] aspect_t;

    localparam aspect_t ASPECT_RED    = 2'd0;
    localparam aspect_t ASPECT_YELLOW = 2'd1;
    localparam aspect_t ASPECT_DOUBLE = 2'd2;
    localparam aspect_t ASPECT_GREEN  = 2'd3;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

// ===== src/block_signal_aspect_controller.sv =====
`default_nettype none

// Four-aspect block signal controller. One request per clock: each request is
// a tick carrying the track-circuit level of every block (0 = shorted, block
// occupied). A low level marks the block occupied at once; a block reads free
// only after its settle counter, started on the first high tick, exceeds
// settle_ticks (reset 1000). The result holds one 2-bit aspect per block
// (0 red, 1 yellow, 2 double yellow, 3 green) and the occupied mask. out_valid
// rises in the cycle after acceptance; the state update and aspect
// decode sit between the block state registers and the output register, so
// a new request is taken every cycle unless a held result is stalled.
// settle_ticks may only be written while no request is in flight.
module block_signal_aspect_controller
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                settle_ticks_we,
    input  wire logic [bsac_pkg::SETTLE_W-1:0]       settle_ticks,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [bsac_pkg::NUM_BLOCKS-1:0]     circuit_levels,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [bsac_pkg::NUM_BLOCKS*bsac_pkg::ASPECT_W-1:0] aspects,
    output logic [bsac_pkg::NUM_BLOCKS-1:0]          occupied_mask
);

    logic [bsac_pkg::SETTLE_W-1:0]   settle_reg;
    logic [bsac_pkg::NUM_BLOCKS-1:0] occ_reg;
    logic [bsac_pkg::NUM_BLOCKS-1:0] occ_next;
    logic [bsac_pkg::NUM_BLOCKS-1:0] clr_reg;
    logic [bsac_pkg::NUM_BLOCKS-1:0] clr_next;
    bsac_pkg::count_t                cnt_reg  [bsac_pkg::NUM_BLOCKS];
    bsac_pkg::count_t                cnt_next [bsac_pkg::NUM_BLOCKS];
    logic [bsac_pkg::NUM_BLOCKS*bsac_pkg::ASPECT_W-1:0] asp_next;
    logic [bsac_pkg::NUM_BLOCKS*bsac_pkg::ASPECT_W-1:0] asp_reg;
    logic [bsac_pkg::NUM_BLOCKS-1:0] mask_reg;
    logic                            valid_reg;
    logic                            accept;

    assign in_stall      = valid_reg & out_stall;
    assign accept        = in_valid & ~in_stall;
    assign out_valid     = valid_reg;
    assign aspects       = asp_reg;
    assign occupied_mask = mask_reg;

    always_comb
    begin
        bsac_pkg::count_t inc;
        occ_next = occ_reg;
        clr_next = clr_reg;
        for (int i = 0; i < bsac_pkg::NUM_BLOCKS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            inc = (cnt_reg[i] == bsac_pkg::COUNT_MAX) ? cnt_reg[i]
                                                      : cnt_reg[i] + 1'b1;
            if (!circuit_levels[i])
            begin
                clr_next[i] = 1'b0;
                cnt_next[i] = '0;
                occ_next[i] = 1'b1;
            end
            else if (clr_reg[i])
            begin
                cnt_next[i] = inc;
                if (inc > {1'b0, settle_reg})
                begin
                    occ_next[i] = 1'b0;
                end
            end
            else
            begin
                // first high tick only starts settling
                clr_next[i] = 1'b1;
                cnt_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        asp_next = '0;
        for (int i = 0; i < bsac_pkg::NUM_BLOCKS; i++)
        begin
            if (occ_next[i])
            begin
                asp_next[i*bsac_pkg::ASPECT_W +: bsac_pkg::ASPECT_W] = bsac_pkg::ASPECT_RED;
            end
            else if (i > 0 && occ_next[(i > 0) ? i-1 : 0])
            begin
                asp_next[i*bsac_pkg::ASPECT_W +: bsac_pkg::ASPECT_W] = bsac_pkg::ASPECT_YELLOW;
            end
            else if (i > 1 && occ_next[(i > 1) ? i-2 : 0])
            begin
                asp_next[i*bsac_pkg::ASPECT_W +: bsac_pkg::ASPECT_W] = bsac_pkg::ASPECT_DOUBLE;
            end
            else
            begin
                asp_next[i*bsac_pkg::ASPECT_W +: bsac_pkg::ASPECT_W] = bsac_pkg::ASPECT_GREEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= bsac_pkg::SETTLE_RESET;
        end
        else if (settle_ticks_we)
        begin
            settle_reg <= settle_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '1;
            clr_reg <= '0;
            for (int i = 0; i < bsac_pkg::NUM_BLOCKS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            occ_reg <= occ_next;
            clr_reg <= clr_next;
            for (int i = 0; i < bsac_pkg::NUM_BLOCKS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            asp_reg  <= asp_next;
            mask_reg <= occ_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bsac_checker.sv =====
`default_nettype none

module bsac_checker
(
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic [bsac_pkg::NUM_BLOCKS-1:0]     circuit_levels,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic [bsac_pkg::NUM_BLOCKS*bsac_pkg::ASPECT_W-1:0] aspects,
    input wire logic [bsac_pkg::NUM_BLOCKS-1:0]     occupied_mask
);

    // red exactly where the block is held occupied
    a_red_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (occupied_mask[0] == (aspects[1:0] == bsac_pkg::ASPECT_RED)) &&
            (occupied_mask[1] == (aspects[3:2] == bsac_pkg::ASPECT_RED)) &&
            (occupied_mask[2] == (aspects[5:4] == bsac_pkg::ASPECT_RED)) &&
            (occupied_mask[3] == (aspects[7:6] == bsac_pkg::ASPECT_RED)))
        else $error("aspect red does not match occupied mask");

    // all circuits shorted gives all blocks occupied on the next result
    a_all_low_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && circuit_levels == '0) |=>
            (out_valid && occupied_mask == '1))
        else $error("shorted circuits not reported occupied");

    // a block behind an occupied one never shows green
    a_yellow_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && occupied_mask[0] && !occupied_mask[1]) |->
            (aspects[3:2] == bsac_pkg::ASPECT_YELLOW))
        else $error("block behind occupied block not yellow");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(aspects) && $stable(occupied_mask)))
        else $error("stalled result changed");

endmodule

bind block_signal_aspect_controller bsac_checker u_bsac_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .circuit_levels (circuit_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .aspects        (aspects),
    .occupied_mask  (occupied_mask)
);

`default_nettype wire
